FILE: hdl/utf8ic_pkg.sv
// Shared types, constants and helpers for the UTF-8 indexed code point picker.
// Used by the channel interfaces, the decode core, the result register and the top level.
package utf8ic_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned CHAR_INDEX_W = 31;
	localparam int unsigned CODE_W       = 21;
	localparam int unsigned STATUS_W     = 2;

	// UTF-8 lead byte patterns and payload masks.
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
	localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
	localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_OOB   = 2'd1,
		ST_TRUNC = 2'd2
	} status_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_point;
		status_t           status;
	} result_t;

	// Number of bytes that follow the given lead byte.
	function automatic logic [1:0] extra_bytes(input logic [BYTE_W-1:0] b);
		logic [1:0] n;
		if ((b & LEAD4_MASK) == LEAD4_PAT) begin
			n = 2'd3;
		end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
			n = 2'd2;
		end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
			n = 2'd1;
		end else begin
			n = 2'd0;
		end
		return n;
	endfunction

endpackage

FILE: hdl/utf8ic_in_if.sv
// Byte input channel of the UTF-8 indexed code point picker: valid/ready plus payload.
// Depends on utf8ic_pkg for the field widths.
interface utf8ic_in_if;
	logic                                valid;
	logic                                ready;
	logic [utf8ic_pkg::BYTE_W-1:0]       data_byte;
	logic [utf8ic_pkg::CHAR_INDEX_W-1:0] char_index;
	logic                                last_byte;

	modport source (output valid, output data_byte, output char_index, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input char_index, input last_byte,
		output ready);
endinterface

FILE: hdl/utf8ic_out_if.sv
// Result channel of the UTF-8 indexed code point picker: valid/ready plus payload.
// Depends on utf8ic_pkg for the field widths and the status type.
interface utf8ic_out_if;
	logic                          valid;
	logic                          ready;
	logic [utf8ic_pkg::CODE_W-1:0] code_point;
	utf8ic_pkg::status_t           status;

	modport source (output valid, output code_point, output status, input ready);
	modport sink (input valid, input code_point, input status, output ready);
endinterface

FILE: hdl/utf8ic_core.sv
// Per-string state and single-pass decode of one byte of the UTF-8 picker.
// Depends on utf8ic_pkg for widths, lead byte helpers and the result type.
module utf8ic_core #(
	parameter int unsigned INDEX_BITS = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [utf8ic_pkg::BYTE_W-1:0]       data_byte,
	input  logic [utf8ic_pkg::CHAR_INDEX_W-1:0] char_index,
	input  logic                                last_byte,
	output utf8ic_pkg::result_t                 res
);

	logic [INDEX_BITS-1:0]         chars_seen_q, target_index_q;
	logic [1:0]                    skip_left_q, cont_left_q;
	logic [utf8ic_pkg::CODE_W-1:0] code_acc_q;
	logic                          found_flag_q, mid_string_q;

	logic [INDEX_BITS-1:0]         chars_cur, target_cur, chars_nxt;
	logic [1:0]                    skip_cur, cont_cur, skip_nxt, cont_nxt, n_extra;
	logic [utf8ic_pkg::CODE_W-1:0] acc_cur, acc_nxt;
	logic                          found_cur, found_nxt;

	// The first byte of a string starts from cleared state and the new index.
	always_comb begin
		if (mid_string_q) begin
			chars_cur  = chars_seen_q;
			target_cur = target_index_q;
			skip_cur   = skip_left_q;
			cont_cur   = cont_left_q;
			acc_cur    = code_acc_q;
			found_cur  = found_flag_q;
		end else begin
			chars_cur  = '0;
			target_cur = INDEX_BITS'(char_index);
			skip_cur   = '0;
			cont_cur   = '0;
			acc_cur    = '0;
			found_cur  = 1'b0;
		end
	end

	assign n_extra = utf8ic_pkg::extra_bytes(data_byte);

	always_comb begin
		chars_nxt = chars_cur;
		skip_nxt  = skip_cur;
		cont_nxt  = cont_cur;
		acc_nxt   = acc_cur;
		found_nxt = found_cur;
		if (found_cur) begin
			if (cont_cur != 2'd0) begin
				acc_nxt  = {acc_cur[utf8ic_pkg::CODE_W-7:0],
					data_byte[5:0] & utf8ic_pkg::CONT_BITS[5:0]};
				cont_nxt = cont_cur - 2'd1;
			end
		end else if (skip_cur != 2'd0) begin
			skip_nxt = skip_cur - 2'd1;
		end else if (chars_cur == target_cur) begin
			found_nxt = 1'b1;
			cont_nxt  = n_extra;
			case (n_extra)
				2'd3:    acc_nxt = utf8ic_pkg::CODE_W'(data_byte & utf8ic_pkg::LEAD4_BITS);
				2'd2:    acc_nxt = utf8ic_pkg::CODE_W'(data_byte & utf8ic_pkg::LEAD3_BITS);
				2'd1:    acc_nxt = utf8ic_pkg::CODE_W'(data_byte & utf8ic_pkg::LEAD2_BITS);
				default: acc_nxt = utf8ic_pkg::CODE_W'(data_byte);
			endcase
		end else begin
			skip_nxt  = n_extra;
			chars_nxt = chars_cur + INDEX_BITS'(1);
		end
	end

	always_comb begin
		if (found_nxt && cont_nxt == 2'd0) begin
			res.code_point = acc_nxt;
			res.status     = utf8ic_pkg::ST_OK;
		end else if (found_nxt) begin
			res.code_point = '0;
			res.status     = utf8ic_pkg::ST_TRUNC;
		end else begin
			res.code_point = '0;
			res.status     = utf8ic_pkg::ST_OOB;
		end
	end

	// Per-string fields are only read while mid_string_q is set, so a last byte
	// needs to clear just that flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_seen_q   <= '0;
			target_index_q <= '0;
			skip_left_q    <= '0;
			cont_left_q    <= '0;
			code_acc_q     <= '0;
			found_flag_q   <= 1'b0;
			mid_string_q   <= 1'b0;
		end else if (step) begin
			chars_seen_q   <= chars_nxt;
			target_index_q <= target_cur;
			skip_left_q    <= skip_nxt;
			cont_left_q    <= cont_nxt;
			code_acc_q     <= acc_nxt;
			found_flag_q   <= found_nxt;
			mid_string_q   <= !last_byte;
		end
	end

`ifndef SYNTH
	a_last_ends_string: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> !mid_string_q)
		else $error("string state still open after its last byte");
	a_cont_only_when_found: assert property (@(posedge clk) disable iff (!arst_n)
		cont_left_q != 2'd0 |-> found_flag_q)
		else $error("continuation bytes owed without a found character");
	a_skip_not_when_found: assert property (@(posedge clk) disable iff (!arst_n)
		found_flag_q |-> skip_left_q == 2'd0)
		else $error("skip count live after the wanted character was found");
`endif

endmodule

FILE: hdl/utf8ic_out_reg.sv
// Result register of the UTF-8 picker: holds one finished result until its transfer.
// Depends on utf8ic_pkg for the result type and on utf8ic_out_if for the channel.
module utf8ic_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  utf8ic_pkg::result_t res,
	output logic                free,
	utf8ic_out_if.source        result
);

	logic                valid_q;
	utf8ic_pkg::result_t res_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result.valid      = valid_q;
	assign result.code_point = res_q.code_point;
	assign result.status     = res_q.status;

`ifndef SYNTH
	a_error_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.status != utf8ic_pkg::ST_OK |-> res_q.code_point == '0)
		else $error("error result carries a nonzero code point");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register loaded while a result is waiting");
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> res_q.status != 2'd3)
		else $error("result status outside its defined codes");
`endif

endmodule

FILE: hdl/utf8_indexed_code_point.sv
// Top level of the UTF-8 indexed code point picker: input register, decode core, result register.
// Depends on utf8ic_pkg, utf8ic_in_if, utf8ic_out_if, utf8ic_core and utf8ic_out_reg.
//
// The block takes one byte of a UTF-8 string per cycle on the bytes channel; the first byte of
// each string carries the wanted character index and the byte flagged last_byte closes the
// string. It counts characters by the length each lead byte announces, decodes the wanted
// character and, for each string, delivers exactly one transfer on the result channel after the
// last byte passes from the input register into the result register: the code point with status
// ok, or zero with status index out of bounds or truncated sequence. A byte passes from the input
// register through one level of decode logic into the per-string counters, so the sustained rate
// is one byte per cycle; bytes.ready drops only while a last byte waits in the input register and
// the result register still holds an untaken result.
module utf8_indexed_code_point #(
	parameter int unsigned INDEX_BITS = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	utf8ic_in_if.sink    bytes,
	utf8ic_out_if.source result
);

	logic                                valid_s1;
	logic [utf8ic_pkg::BYTE_W-1:0]       data_byte_s1;
	logic [utf8ic_pkg::CHAR_INDEX_W-1:0] char_index_s1;
	logic                                last_byte_s1;

	logic                free;
	logic                step;
	utf8ic_pkg::result_t res;

	// A byte that closes no string never needs the result register.
	assign step        = valid_s1 && (!last_byte_s1 || free);
	assign bytes.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_byte_s1  <= bytes.data_byte;
			char_index_s1 <= bytes.char_index;
			last_byte_s1  <= bytes.last_byte;
		end
	end

	utf8ic_core #(
		.INDEX_BITS (INDEX_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (data_byte_s1),
		.char_index (char_index_s1),
		.last_byte  (last_byte_s1),
		.res        (res)
	);

	utf8ic_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && last_byte_s1),
		.res    (res),
		.free   (free),
		.result (result)
	);

`ifndef SYNTH
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte_s1 |=> result.valid)
		else $error("last byte processed without a result");
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> bytes.ready)
		else $error("input stalled while the result register is empty");
	a_plain_byte_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_byte_s1 |-> step)
		else $error("byte that closes no string was held back");
`endif

endmodule

FILE: tb/tb_utf8_indexed_code_point.sv
// Self-checking testbench for the UTF-8 indexed code point picker: drives byte strings and
// compares every result transfer with a code point predicted from the accepted bytes.
// Depends on utf8ic_pkg, utf8ic_in_if, utf8ic_out_if and utf8_indexed_code_point.
module tb_utf8_indexed_code_point;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned INDEX_BITS  = 31;
	localparam int unsigned PHASE_BYTES = 383;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [utf8ic_pkg::BYTE_W-1:0]       data;
		logic [utf8ic_pkg::CHAR_INDEX_W-1:0] index;
		logic                                last;
	} byte_item_t;

	logic clk;
	logic arst_n;

	utf8ic_in_if  bytes ();
	utf8ic_out_if result ();

	utf8_indexed_code_point #(
		.INDEX_BITS(INDEX_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (bytes),
		.result(result)
	);

	byte_item_t          bytes_to_send[$];
	utf8ic_pkg::result_t code_points_due[$];
	int unsigned         bytes_queued;
	int unsigned         send_idle;
	int unsigned         recv_idle;
	int unsigned         errors;
	int unsigned         cycles;

	// Predictor state for the string in flight.
	logic [INDEX_BITS-1:0]         seen_chars;
	logic [INDEX_BITS-1:0]         want_index;
	logic [1:0]                    skip_cnt;
	logic [1:0]                    cont_cnt;
	logic [utf8ic_pkg::CODE_W-1:0] acc_cp;
	logic                          hit;
	logic                          in_string;

	always begin
		#5ns clk = ~clk;
	end

	// Continuation bytes that follow a lead byte; anything else stands alone.
	function automatic logic [1:0] follow_count(input logic [utf8ic_pkg::BYTE_W-1:0] b);
		casez (b)
			8'b11110???: return 2'd3;
			8'b1110????: return 2'd2;
			8'b110?????: return 2'd1;
			default:     return 2'd0;
		endcase
	endfunction

	task automatic track_byte(input byte_item_t it);
		utf8ic_pkg::result_t r;
		if (!in_string) begin
			seen_chars = '0;
			want_index = INDEX_BITS'(it.index);
			skip_cnt   = '0;
			cont_cnt   = '0;
			acc_cp     = '0;
			hit        = 1'b0;
		end
		if (hit) begin
			if (cont_cnt != 0) begin
				acc_cp   = {acc_cp[utf8ic_pkg::CODE_W-7:0], it.data[5:0]};
				cont_cnt = cont_cnt - 2'd1;
			end
		end else if (skip_cnt != 0) begin
			skip_cnt = skip_cnt - 2'd1;
		end else if (seen_chars == want_index) begin
			hit      = 1'b1;
			cont_cnt = follow_count(it.data);
			case (cont_cnt)
				2'd3:    acc_cp = utf8ic_pkg::CODE_W'(it.data[2:0]);
				2'd2:    acc_cp = utf8ic_pkg::CODE_W'(it.data[3:0]);
				2'd1:    acc_cp = utf8ic_pkg::CODE_W'(it.data[4:0]);
				default: acc_cp = utf8ic_pkg::CODE_W'(it.data);
			endcase
		end else begin
			skip_cnt   = follow_count(it.data);
			seen_chars = seen_chars + INDEX_BITS'(1);
		end
		if (!it.last) begin
			in_string = 1'b1;
		end else begin
			r.code_point = '0;
			if (hit && cont_cnt == 0) begin
				r.code_point = acc_cp;
				r.status     = utf8ic_pkg::ST_OK;
			end else if (hit) begin
				r.status = utf8ic_pkg::ST_TRUNC;
			end else begin
				r.status = utf8ic_pkg::ST_OOB;
			end
			code_points_due.push_back(r);
			in_string = 1'b0;
		end
	endtask

	// The index rides on the first byte only; later bytes carry random noise there.
	task automatic send_text(input logic [utf8ic_pkg::CHAR_INDEX_W-1:0] idx,
		input logic [utf8ic_pkg::BYTE_W-1:0] text[$]);
		byte_item_t it;
		for (int i = 0; i < text.size(); i++) begin
			it.data  = text[i];
			it.index = (i == 0) ? idx : utf8ic_pkg::CHAR_INDEX_W'($urandom);
			it.last  = (i == text.size() - 1);
			bytes_to_send.push_back(it);
			bytes_queued++;
		end
	endtask

	task automatic send_random_string();
		logic [utf8ic_pkg::BYTE_W-1:0]       text[$];
		logic [utf8ic_pkg::CHAR_INDEX_W-1:0] idx;
		int unsigned                         nchars;
		int unsigned                         len;
		int unsigned                         kind;
		int unsigned                         pick;
		int unsigned                         cut;
		nchars = $urandom_range(1, 6);
		kind   = $urandom_range(0, 99);
		for (int c = 0; c < nchars; c++) begin
			len = $urandom_range(1, 4);
			case (len)
				1:       text.push_back({1'b0, 7'($urandom)});
				2:       text.push_back({3'b110, 5'($urandom)});
				3:       text.push_back({4'b1110, 4'($urandom)});
				default: text.push_back({5'b11110, 3'($urandom)});
			endcase
			for (int k = 1; k < len; k++) begin
				if ($urandom_range(0, 99) < 85) begin
					text.push_back({2'b10, 6'($urandom)});
				end else begin
					text.push_back(8'($urandom));
				end
			end
		end
		if (kind < 10) begin
			// Plain noise: any byte values at all.
			text.delete();
			len = $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				text.push_back(8'($urandom));
			end
		end else if (kind < 20) begin
			cut = $urandom_range(1, 3);
			while (cut > 0 && text.size() > 1) begin
				void'(text.pop_back());
				cut--;
			end
		end
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			idx = utf8ic_pkg::CHAR_INDEX_W'($urandom_range(0, nchars - 1));
		end else if (pick < 85) begin
			idx = utf8ic_pkg::CHAR_INDEX_W'(nchars + $urandom_range(0, 2));
		end else begin
			idx = utf8ic_pkg::CHAR_INDEX_W'($urandom);
		end
		send_text(idx, text);
	endtask

	task automatic send_directed();
		logic [utf8ic_pkg::BYTE_W-1:0] text[$];
		text = {8'h00};                      send_text(0, text);
		text = {8'hFF};                      send_text(0, text);
		text = {8'h7F};                      send_text(1, text);
		text = {8'hF7, 8'hFF, 8'hFF, 8'hFF}; send_text(0, text);
		text = {8'hE2, 8'h82, 8'hAC};        send_text(0, text);
		text = {8'hC3, 8'hA9};               send_text(0, text);
		text = {8'hE2, 8'h82};               send_text(0, text);
		// A skipped four-byte character runs past the end of the string.
		text = {8'hF0, 8'h80};               send_text(1, text);
		text = {8'h41, 8'hC3, 8'hA9, 8'h42}; send_text(1, text);
		text = {8'h41};                      send_text(31'h7FFF_FFFF, text);
		text = {8'h80};                      send_text(0, text);
		text = {8'hC3};                      send_text(0, text);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		byte_item_t nxt;
		byte_item_t taken;
		if (!arst_n) begin
			bytes.valid      <= 1'b0;
			bytes.data_byte  <= '0;
			bytes.char_index <= '0;
			bytes.last_byte  <= 1'b0;
		end else begin
			if (bytes.valid && bytes.ready) begin
				taken.data  = bytes.data_byte;
				taken.index = bytes.char_index;
				taken.last  = bytes.last_byte;
				track_byte(taken);
			end
			if (!bytes.valid || bytes.ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					nxt = bytes_to_send.pop_front();
					bytes.valid      <= 1'b1;
					bytes.data_byte  <= nxt.data;
					bytes.char_index <= nxt.index;
					bytes.last_byte  <= nxt.last;
				end else begin
					bytes.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		utf8ic_pkg::result_t due;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (code_points_due.size() == 0) begin
					$display("%0t: unexpected result transfer: expected none, actual %h/%s",
						$realtime, result.code_point, result.status.name());
					errors++;
				end else begin
					due = code_points_due.pop_front();
					if (result.code_point !== due.code_point || result.status !== due.status) begin
						$display("%0t: result mismatch: expected %h/%s, actual %h/%s",
							$realtime, due.code_point, due.status.name(),
							result.code_point, result.status.name());
						errors++;
					end
				end
			end
			result.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int unsigned phase_start;
		clk              = 1'b0;
		arst_n           = 1'b0;
		bytes.valid      = 1'b0;
		bytes.data_byte  = '0;
		bytes.char_index = '0;
		bytes.last_byte  = 1'b0;
		result.ready     = 1'b0;
		in_string        = 1'b0;
		errors           = 0;
		cycles           = 0;
		bytes_queued     = 0;
		send_idle        = 15;
		recv_idle        = 75;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_directed();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin send_idle = 15; recv_idle = 75; end
				1:       begin send_idle = 75; recv_idle = 15; end
				default: begin send_idle = 0;  recv_idle = 0;  end
			endcase
			phase_start = bytes_queued;
			while (bytes_queued - phase_start < PHASE_BYTES) begin
				send_random_string();
			end
			while (bytes_to_send.size() != 0 || bytes.valid) begin
				@(negedge clk);
			end
		end

		while (code_points_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/utf8ic_pkg.sv
hdl/utf8ic_in_if.sv
hdl/utf8ic_out_if.sv
hdl/utf8ic_core.sv
hdl/utf8ic_out_reg.sv
hdl/utf8_indexed_code_point.sv
tb/tb_utf8_indexed_code_point.sv
